// ===== design/sfstep_pkg.sv =====
`default_nettype none

package sfstep_pkg;

   // star table and screen
   localparam int STAR_COUNT = 256;
   localparam int STAR_ADDR_W = (STAR_COUNT > 1) ? $clog2(STAR_COUNT) : 1;
   localparam int SCREEN_W = 200;
   localparam int SCREEN_H = 200;

   // stream widths
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;

   // csr register indexes
   localparam logic [0:0] CSR_FLIGHT_RATE = 1'b0;
   localparam logic [0:0] CSR_RNG_SEED    = 1'b1;

   // request commands carried in tuser
   localparam logic CMD_RESPAWN = 1'b0;
   localparam logic CMD_ADVANCE = 1'b1;

   // generator: state * mul + add, draw is bits 30:16
   localparam logic [31:0] LCG_MUL = 32'd1103515245;
   localparam logic [31:0] LCG_ADD = 32'd12345;
   localparam int DRAW_W = 15;
   localparam int DRAW_CNT_W = 4;

   // serial divider
   localparam int DIV_W = 32;
   localparam int DIV_CNT_W = 5;

   // respawn ranges
   localparam int DEPTH_MIN = 255 / 6;
   localparam int DEPTH_MAX = 255;
   localparam logic [7:0] HALF_W = 8'(SCREEN_W / 2);
   localparam logic [7:0] HALF_H = 8'(SCREEN_H / 2);
   localparam logic [7:0] SPAN_X = 8'(2 * (SCREEN_W / 2) + 1);
   localparam logic [7:0] SPAN_Y = 8'(2 * (SCREEN_H / 2) + 1);
   localparam logic [7:0] SPAN_Z = 8'(DEPTH_MAX - DEPTH_MIN + 1);
   localparam logic [7:0] DEPTH_BASE = 8'(DEPTH_MIN);

   // projection window in q.8
   localparam logic [15:0] CENTRE_X_Q8 = 16'((SCREEN_W / 2) * 256);
   localparam logic [15:0] CENTRE_Y_Q8 = 16'((SCREEN_H / 2) * 256);
   localparam logic [15:0] LIMIT_X_Q8 = 16'((SCREEN_W - 1) * 256);
   localparam logic [15:0] LIMIT_Y_Q8 = 16'((SCREEN_H - 1) * 256);

   localparam logic [15:0] BRIGHT_TOP = 16'(255 * 256);

   typedef struct packed {
      logic [15:0] depth;
      logic [7:0]  y;
      logic [7:0]  x;
   } star_type;

   typedef struct packed {
      logic       start;
      logic [7:0] span;
   } rng_req_type;

   typedef struct packed {
      logic       done;
      logic [7:0] value;
   } rng_res_type;

   typedef struct packed {
      logic       done;
      logic       off_screen;
      logic [7:0] coord;
   } proj_res_type;

   typedef struct packed {
      logic       load;
      logic [7:0] cx;
      logic [7:0] cy;
      logic [7:0] bright;
   } emit_cmd_type;

endpackage

`default_nettype wire

// ===== design/sfstep_rng.sv =====
`default_nettype none

module sfstep_rng (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      seed_we,
   input  wire logic [31:0]               seed,
   input  wire sfstep_pkg::rng_req_type   req,
   output sfstep_pkg::rng_res_type        res
);
   import sfstep_pkg::*;

   localparam logic R_IDLE = 1'b0;
   localparam logic R_MOD  = 1'b1;

   logic                  state_ff, state_in;
   logic [31:0]           lcg_ff, lcg_in;
   logic [31:0]           lcg_next;
   logic [DRAW_W-1:0]     draw_ff, draw_in;
   logic [7:0]            rem_ff, rem_in;
   logic [7:0]            span_ff, span_in;
   logic [DRAW_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  done_ff, done_in;
   logic [8:0]            trial;
   logic [8:0]            trial_sub;

   assign lcg_next  = lcg_ff * LCG_MUL + LCG_ADD;
   // one remainder bit per cycle
   assign trial     = {rem_ff, draw_ff[DRAW_W-1]};
   assign trial_sub = trial - {1'b0, span_ff};

   always_comb begin
      state_in = state_ff;
      lcg_in   = lcg_ff;
      draw_in  = draw_ff;
      rem_in   = rem_ff;
      span_in  = span_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         R_IDLE: begin
            if (seed_we) begin
               lcg_in = seed;
            end else if (req.start) begin
               lcg_in   = lcg_next;
               draw_in  = lcg_next[DRAW_W+15:16];
               rem_in   = '0;
               span_in  = req.span;
               cnt_in   = '0;
               state_in = R_MOD;
            end
         end
         R_MOD: begin
            rem_in  = (trial >= {1'b0, span_ff}) ? trial_sub[7:0] : trial[7:0];
            draw_in = {draw_ff[DRAW_W-2:0], 1'b0};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == DRAW_CNT_W'(DRAW_W - 1)) begin
               done_in  = 1'b1;
               state_in = R_IDLE;
            end
         end
         default: state_in = R_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= R_IDLE;
         lcg_ff   <= 32'd1;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         lcg_ff   <= lcg_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      draw_ff <= draw_in;
      rem_ff  <= rem_in;
      span_ff <= span_in;
   end

   assign res.done  = done_ff;
   assign res.value = rem_ff;

endmodule

`default_nettype wire

// ===== design/sfstep_proj.sv =====
`default_nettype none

module sfstep_proj (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [7:0]               offset,
   input  wire logic [15:0]              depth,
   input  wire logic [15:0]              centre,
   input  wire logic [15:0]              limit_hi,
   output sfstep_pkg::proj_res_type      res
);
   import sfstep_pkg::*;

   localparam logic [2:0] P_IDLE = 3'd0;
   localparam logic [2:0] P_RUN  = 3'd1;
   localparam logic [2:0] P_SIGN = 3'd2;
   localparam logic [2:0] P_ADD  = 3'd3;
   localparam logic [2:0] P_CHK  = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 neg_ff, neg_in;
   logic [DIV_W-1:0]     qd_ff, qd_in;
   logic [15:0]          rem_ff, rem_in;
   logic [15:0]          den_ff, den_in;
   logic signed [32:0]   sq_ff, sq_in;
   logic signed [33:0]   pos_ff, pos_in;
   logic                 done_ff, done_in;
   logic                 off_ff, off_in;
   logic [7:0]           coord_ff, coord_in;
   logic [7:0]           mag;
   logic [16:0]          trial;
   logic [16:0]          trial_sub;
   logic                 fits;
   logic [16:0]          rounded;

   assign mag       = offset[7] ? 8'(-offset) : offset;
   // restoring division, one quotient bit per cycle
   assign trial     = {rem_ff, qd_ff[DIV_W-1]};
   assign trial_sub = trial - {1'b0, den_ff};
   assign fits      = trial >= {1'b0, den_ff};
   assign rounded   = {1'b0, pos_ff[15:0]} + 17'd128;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      qd_in    = qd_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      sq_in    = sq_ff;
      pos_in   = pos_ff;
      done_in  = 1'b0;
      off_in   = off_ff;
      coord_in = coord_ff;
      unique case (state_ff)
         P_IDLE: begin
            if (start) begin
               neg_in   = offset[7];
               qd_in    = {mag, (DIV_W - 8)'(0)};
               rem_in   = '0;
               den_in   = depth;
               cnt_in   = '0;
               state_in = P_RUN;
            end
         end
         P_RUN: begin
            rem_in = fits ? trial_sub[15:0] : trial[15:0];
            qd_in  = {qd_ff[DIV_W-2:0], fits};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
               state_in = P_SIGN;
            end
         end
         P_SIGN: begin
            sq_in    = neg_ff ? -$signed({1'b0, qd_ff}) : $signed({1'b0, qd_ff});
            state_in = P_ADD;
         end
         P_ADD: begin
            pos_in   = 34'(sq_ff) + $signed({18'd0, centre});
            state_in = P_CHK;
         end
         P_CHK: begin
            off_in   = (pos_ff < 34'sd256) || (pos_ff > $signed({18'd0, limit_hi}));
            coord_in = rounded[15:8];
            done_in  = 1'b1;
            state_in = P_IDLE;
         end
         default: state_in = P_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= P_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff   <= neg_in;
      qd_ff    <= qd_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      sq_ff    <= sq_in;
      pos_ff   <= pos_in;
      off_ff   <= off_in;
      coord_ff <= coord_in;
   end

   assign res.done       = done_ff;
   assign res.off_screen = off_ff;
   assign res.coord      = coord_ff;

endmodule

`default_nettype wire

// ===== design/sfstep_emit.sv =====
`default_nettype none

module sfstep_emit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire sfstep_pkg::emit_cmd_type          cmd,
   output logic                                   ready,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [sfstep_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                   rsp_tlast
);
   import sfstep_pkg::*;

   // pending writes: centre, left, right, up, down
   logic [4:0] mask_ff, mask_in;
   logic [4:0] mask_rest;
   logic [4:0] mask_new;
   logic [7:0] cx_ff, cy_ff, bright_ff;
   logic [7:0] pix_x, pix_y;
   logic [8:0] cx_up, cy_up;

   assign cx_up     = {1'b0, cmd.cx} + 9'd1;
   assign cy_up     = {1'b0, cmd.cy} + 9'd1;
   assign mask_new  = {cy_up < 9'(SCREEN_H), cmd.cy != 8'd0,
                       cx_up < 9'(SCREEN_W), cmd.cx != 8'd0,
                       ({1'b0, cmd.cx} < 9'(SCREEN_W)) && ({1'b0, cmd.cy} < 9'(SCREEN_H))};
   // lowest pending write goes first
   assign mask_rest = mask_ff & (mask_ff - 5'd1);

   always_comb begin
      pix_x = cx_ff;
      pix_y = cy_ff;
      if (mask_ff[0]) begin
         pix_x = cx_ff;
      end else if (mask_ff[1]) begin
         pix_x = cx_ff - 8'd1;
      end else if (mask_ff[2]) begin
         pix_x = cx_ff + 8'd1;
      end else if (mask_ff[3]) begin
         pix_y = cy_ff - 8'd1;
      end else begin
         pix_y = cy_ff + 8'd1;
      end
   end

   always_comb begin
      mask_in = mask_ff;
      if (cmd.load) begin
         mask_in = mask_new;
      end else if (rsp_tvalid && rsp_tready) begin
         mask_in = mask_rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cx_ff     <= cmd.cx;
         cy_ff     <= cmd.cy;
         bright_ff <= cmd.bright;
      end
   end

   assign ready      = (mask_ff == 5'd0);
   assign rsp_tvalid = |mask_ff;
   assign rsp_tlast  = (mask_rest == 5'd0);
   assign rsp_tdata  = {bright_ff, pix_y, pix_x};

`ifndef SYNTHESIS
   a_load_when_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (mask_ff == 5'd0))
      else $error("pixel group loaded over pending writes");

   a_one_write_per_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready) |=> ($countones(mask_ff) == $countones($past(mask_ff)) - 1))
      else $error("pending write count did not drop by one");
`endif

endmodule

`default_nettype wire

// ===== design/starfield_star_step.sv =====
// starfield_star_step: star table, generator and perspective projection
// request channel (req_*): one word per star command; tuser is the command
// (0 respawn, 1 advance and draw), tdata holds star index and frame delta
// response channel (rsp_*): one word per pixel write, tlast on the final
// write of a star; a star gives zero to five words
// csr channel: index 0 flight_rate, index 1 rng_seed (loads the generator);
// always ready, write only while the block is idle
// respawn takes three generator draws, each from the bit-serial remainder unit,
// plus a store state; the next request word waits until the store is done
// a step that stays on screen reads the table, updates the depth and runs
// the serial dividers for x and y (run side by side) before its first pixel
// word; an off-screen star adds a respawn and gives no words
// items are handled one at a time; the next request word is taken as soon
// as a star's pixels are handed to the output stage, while they still drain
// when rsp_tready is low the output stage holds its word and the next
// star waits before its hand-off until the stage is empty
// reset clears the sequencer, sets flight_rate to 66 and the generator to 1;
// the star table is not cleared and must be written by respawn first
`default_nettype none

module starfield_star_step (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [sfstep_pkg::REQ_DATA_W-1:0] req_tdata,  // star_index[7:0], delta[23:8]
   input  wire logic                              req_tuser,  // command[0]
   // response
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [sfstep_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // pixel_x[7:0], pixel_y[15:8],
                                                              // brightness[23:16]
   output logic                                   rsp_tlast,  // last
   // configuration
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [0:0]                        csr_index,
   input  wire logic [31:0]                       csr_data
);
   import sfstep_pkg::*;

   localparam logic [1:0] DRAW_X = 2'd0;
   localparam logic [1:0] DRAW_Y = 2'd1;
   localparam logic [1:0] DRAW_Z = 2'd2;

   // sequencer states
   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_READ    = 4'd1;
   localparam logic [3:0] S_CALC    = 4'd2;
   localparam logic [3:0] S_DRAW_GO = 4'd3;
   localparam logic [3:0] S_DRAW    = 4'd4;
   localparam logic [3:0] S_STORE   = 4'd5;
   localparam logic [3:0] S_PROJ    = 4'd6;
   localparam logic [3:0] S_PWAIT   = 4'd7;
   localparam logic [3:0] S_EMIT    = 4'd8;

   logic [3:0]  state_ff, state_in;
   logic [7:0]  idx_ff, idx_in;
   logic [15:0] dec_ff, dec_in;
   logic [7:0]  x_ff, x_in;
   logic [7:0]  y_ff, y_in;
   logic [15:0] depth_ff, depth_in;
   logic [1:0]  draw_ff, draw_in;
   logic        proj_after_ff, proj_after_in;
   logic [7:0]  cx_ff, cx_in;
   logic [7:0]  cy_ff, cy_in;
   logic [7:0]  flight_rate_ff;

   star_type    star_mem [STAR_COUNT];
   star_type    rd_ff;
   star_type    mem_wdata;
   logic        mem_we;
   logic [STAR_ADDR_W-1:0] mem_addr;

   logic [23:0] dec_prod;
   logic        in_range;
   logic [15:0] bright_sub;
   logic [7:0]  bright;
   logic [7:0]  span_sel;
   logic        seed_we;

   rng_req_type  rng_req;
   rng_res_type  rng_res;
   logic         proj_start;
   proj_res_type px_res, py_res;
   emit_cmd_type emit_cmd;
   logic         emit_ready;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign seed_we    = csr_valid && (csr_index == CSR_RNG_SEED);

   // depth lost this frame, q8.8
   assign dec_prod   = 24'(req_tdata[23:8]) * 24'(flight_rate_ff);
   assign in_range   = 32'(req_tdata[7:0]) < 32'(STAR_COUNT);
   assign mem_addr   = STAR_ADDR_W'(idx_ff);
   assign bright_sub = BRIGHT_TOP - depth_ff;
   assign bright     = (depth_ff > BRIGHT_TOP) ? 8'd0 : bright_sub[15:8];

   always_comb begin
      unique case (draw_ff)
         DRAW_X:  span_sel = SPAN_X;
         DRAW_Y:  span_sel = SPAN_Y;
         DRAW_Z:  span_sel = SPAN_Z;
         default: span_sel = SPAN_Z;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      dec_in        = dec_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      depth_in      = depth_ff;
      draw_in       = draw_ff;
      proj_after_in = proj_after_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      mem_we        = 1'b0;
      mem_wdata     = '{depth: depth_ff, y: y_ff, x: x_ff};
      rng_req       = '{start: 1'b0, span: span_sel};
      proj_start    = 1'b0;
      emit_cmd      = '{load: 1'b0, cx: cx_ff, cy: cy_ff, bright: bright};
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               idx_in = req_tdata[7:0];
               dec_in = dec_prod[23:8];
               if (in_range) begin
                  if (req_tuser == CMD_RESPAWN) begin
                     proj_after_in = 1'b0;
                     draw_in       = DRAW_X;
                     state_in      = S_DRAW_GO;
                  end else begin
                     state_in = S_READ;
                  end
               end
            end
         end
         S_READ: state_in = S_CALC;
         S_CALC: begin
            if (rd_ff.depth <= dec_ff) begin
               // depth reached zero: fresh star, then project it
               proj_after_in = 1'b1;
               draw_in       = DRAW_X;
               state_in      = S_DRAW_GO;
            end else begin
               x_in      = rd_ff.x;
               y_in      = rd_ff.y;
               depth_in  = rd_ff.depth - dec_ff;
               mem_we    = 1'b1;
               mem_wdata = '{depth: rd_ff.depth - dec_ff, y: rd_ff.y, x: rd_ff.x};
               state_in  = S_PROJ;
            end
         end
         S_DRAW_GO: begin
            rng_req.start = 1'b1;
            state_in      = S_DRAW;
         end
         S_DRAW: begin
            if (rng_res.done) begin
               unique case (draw_ff)
                  DRAW_X: begin
                     x_in     = rng_res.value - HALF_W;
                     draw_in  = DRAW_Y;
                     state_in = S_DRAW_GO;
                  end
                  DRAW_Y: begin
                     y_in     = rng_res.value - HALF_H;
                     draw_in  = DRAW_Z;
                     state_in = S_DRAW_GO;
                  end
                  default: begin
                     depth_in = {rng_res.value + DEPTH_BASE, 8'd0};
                     state_in = S_STORE;
                  end
               endcase
            end
         end
         S_STORE: begin
            mem_we   = 1'b1;
            state_in = proj_after_ff ? S_PROJ : S_IDLE;
         end
         S_PROJ: begin
            proj_start = 1'b1;
            state_in   = S_PWAIT;
         end
         S_PWAIT: begin
            if (px_res.done) begin
               if (px_res.off_screen || py_res.off_screen) begin
                  proj_after_in = 1'b0;
                  draw_in       = DRAW_X;
                  state_in      = S_DRAW_GO;
               end else begin
                  cx_in    = px_res.coord;
                  cy_in    = py_res.coord;
                  state_in = S_EMIT;
               end
            end
         end
         S_EMIT: begin
            emit_cmd.load = emit_ready;
            if (emit_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         draw_ff       <= DRAW_X;
         proj_after_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         draw_ff       <= draw_in;
         proj_after_ff <= proj_after_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      dec_ff   <= dec_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      depth_ff <= depth_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         flight_rate_ff <= 8'd66;
      end else if (csr_valid && (csr_index == CSR_FLIGHT_RATE)) begin
         flight_rate_ff <= csr_data[7:0];
      end
   end

   // star table, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         star_mem[mem_addr] <= mem_wdata;
      end
      rd_ff <= star_mem[mem_addr];
   end

   sfstep_rng u_rng (
      .clock   (clock),
      .reset   (reset),
      .seed_we (seed_we),
      .seed    (csr_data),
      .req     (rng_req),
      .res     (rng_res)
   );

   sfstep_proj u_proj_x (
      .clock    (clock),
      .reset    (reset),
      .start    (proj_start),
      .offset   (x_ff),
      .depth    (depth_ff),
      .centre   (CENTRE_X_Q8),
      .limit_hi (LIMIT_X_Q8),
      .res      (px_res)
   );

   sfstep_proj u_proj_y (
      .clock    (clock),
      .reset    (reset),
      .start    (proj_start),
      .offset   (y_ff),
      .depth    (depth_ff),
      .centre   (CENTRE_Y_Q8),
      .limit_hi (LIMIT_Y_Q8),
      .res      (py_res)
   );

   sfstep_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .cmd        (emit_cmd),
      .ready      (emit_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTHESIS
   a_proj_lockstep: assert property (@(posedge clock) disable iff (reset)
      px_res.done == py_res.done)
      else $error("x and y dividers out of step");

   a_draw_expected: assert property (@(posedge clock) disable iff (reset)
      rng_res.done |-> (state_ff == S_DRAW))
      else $error("generator result with no draw pending");

   a_proj_expected: assert property (@(posedge clock) disable iff (reset)
      px_res.done |-> (state_ff == S_PWAIT))
      else $error("projection result with no projection pending");
`endif

endmodule

`default_nettype wire
